FILE: rtl/core/utf8sd_pkg.sv
package utf8sd_pkg;

  localparam int CP_W = 21;
  localparam int BYTE_W = 8;

  // Result queue geometry; a decode step may push two results.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int MAX_PUSH = 2;

  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

  localparam logic [1:0] CONT_TAG = 2'b10;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [2:0] LEAD2_TAG = 3'b110;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            error;
    logic            last;
  } result_t;

  // Results of one decode step, in emission order.
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } dec_out_t;

endpackage

FILE: rtl/core/utf8sd_dec.sv
module utf8sd_dec
  import utf8sd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] byte_in,
  output dec_out_t          dec_out
);

  logic [1:0]      bytes_left_r, bytes_left_nxt;
  logic [CP_W-1:0] partial_r, partial_nxt;

  function automatic result_t mk_ok(input logic [CP_W-1:0] cp);
    result_t r;
    r.code_point = cp;
    r.error = 1'b0;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_err();
    result_t r;
    r.code_point = '0;
    r.error = 1'b1;
    r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic            cont;
    logic            lead;
    logic [CP_W-1:0] pp;
    result_t         res [MAX_PUSH];
    logic [1:0]      k;

    cont = (byte_in[7:6] == CONT_TAG);
    lead = 1'b1;
    pp = {partial_r[CP_W-7:0], byte_in[5:0]};
    res[0] = mk_err();
    res[1] = mk_err();
    k = 2'd0;
    bytes_left_nxt = bytes_left_r;
    partial_nxt = partial_r;

    if (bytes_left_r != 2'd0) begin
      if (cont) begin
        lead = 1'b0;
        bytes_left_nxt = bytes_left_r - 2'd1;
        partial_nxt = pp;
        if (bytes_left_r == 2'd1) begin
          if (pp > CP_MAX || (pp >= SURR_LO && pp <= SURR_HI)) begin
            res[0] = mk_err();
          end else begin
            res[0] = mk_ok(pp);
          end
          k = 2'd1;
          partial_nxt = '0;
        end
      end else begin
        // Interrupted sequence: flag it, then decode this byte as a lead.
        res[0] = mk_err();
        k = 2'd1;
        bytes_left_nxt = 2'd0;
        partial_nxt = '0;
      end
    end

    if (lead) begin
      if (!byte_in[7]) begin
        res[k[0]] = mk_ok({{(CP_W-BYTE_W){1'b0}}, byte_in});
        k = k + 2'd1;
      end else if (byte_in[7:3] == LEAD4_TAG) begin
        partial_nxt = {{(CP_W-3){1'b0}}, byte_in[2:0]};
        bytes_left_nxt = 2'd3;
      end else if (byte_in[7:4] == LEAD3_TAG) begin
        partial_nxt = {{(CP_W-4){1'b0}}, byte_in[3:0]};
        bytes_left_nxt = 2'd2;
      end else if (byte_in[7:5] == LEAD2_TAG) begin
        partial_nxt = {{(CP_W-5){1'b0}}, byte_in[4:0]};
        bytes_left_nxt = 2'd1;
      end else begin
        res[k[0]] = mk_err();
        k = k + 2'd1;
      end
    end

    if (k == 2'd2) begin
      res[1].last = 1'b1;
    end else begin
      res[0].last = 1'b1;
    end

    dec_out.num = k;
    dec_out.r0 = res[0];
    dec_out.r1 = res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 2'd0;
      partial_r <= '0;
    end else if (step) begin
      bytes_left_r <= bytes_left_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

FILE: rtl/core/utf8sd_rq.sv
module utf8sd_rq
  import utf8sd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dec_out_t          push_data,
  input  logic              pop,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count,
  output result_t           head
);

  result_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]        n_push;
  logic [QPTR_W-1:0] wr_ptr1;

  assign n_push = push ? push_data.num : 2'd0;
  assign wr_ptr1 = wr_ptr_r + QPTR_W'(1);
  assign cnt_nxt = cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);

  assign not_empty = (cnt_r != '0);
  assign count = cnt_r;
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push_data.r0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr1] <= push_data.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder: takes one byte word per cycle while the result queue has
// room and delivers decoded code points with an error flag and a last flag marking
// the final result of each byte. A byte is registered on acceptance, decoded once
// the queue has room for two results, and its zero, one or two results enter a
// four-entry result queue whose head drives the output; the first result is thus
// offered after both the byte register and the queue have been written. The
// sequence state (continuation count and partial point) is updated in that single
// decode step, which is what allows one byte per cycle; a byte that yields two
// results is still delivered one result at a time. The input stays ready as long
// as the queue holds at most two results.
module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_error,
  output logic            out_last
);

  logic              in_vld_r, in_vld_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              consume;
  logic              pop;
  logic              q_not_empty;
  logic [QCNT_W-1:0] q_count;
  dec_out_t          dec_out;
  result_t           head;

  // A held byte is decoded only when the queue has room for two results.
  assign consume = in_vld_r && (q_count <= QCNT_W'(QDEPTH - MAX_PUSH));
  assign in_ready = !in_vld_r || consume;
  assign in_vld_nxt = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_in;
    end
  end

  utf8sd_dec u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (consume),
    .byte_in (byte_r),
    .dec_out (dec_out)
  );

  assign pop = q_not_empty && out_ready;

  utf8sd_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (consume),
    .push_data (dec_out),
    .pop       (pop),
    .not_empty (q_not_empty),
    .count     (q_count),
    .head      (head)
  );

  assign out_valid = q_not_empty;
  assign out_code_point = head.code_point;
  assign out_error = head.error;
  assign out_last = head.last;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QDEPTH))
    else $error("result queue count exceeds its depth");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    consume && dec_out.num == 2'd2 |-> !dec_out.r0.last && dec_out.r1.last
      && dec_out.r0.error)
    else $error("two-result byte must lead with an error and end on last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_code_point == '0)
    else $error("error result carries a nonzero code point");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    consume |=> q_count <= QCNT_W'(QDEPTH))
    else $error("decode step overran the result queue");

endmodule

FILE: dv/utf8_stream_decoder_checker.sv
`timescale 1ns / 100ps

module utf8_stream_decoder_checker
  import utf8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [7:0]      in_byte_in,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [CP_W-1:0] out_code_point,
  input  logic            out_error,
  input  logic            out_last,
  output int              fail_count,
  output int              outstanding,
  output int              checked_count,
  output int              error_count
);

  // Expected decoder output, oldest first.
  result_t expected_points [$];

  // Shadow copy of the open sequence.
  logic [1:0]      seq_left;
  logic [CP_W-1:0] seq_point;

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    checked_count = 0;
    error_count   = 0;
    seq_left      = '0;
    seq_point     = '0;
  end

  function automatic result_t make_result(input logic [CP_W-1:0] cp, input logic err);
    result_t r;
    r.code_point = err ? '0 : cp;
    r.error      = err;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic scalar_ok(input logic [CP_W-1:0] p);
    return (p <= CP_MAX) && !((p >= SURR_LO) && (p <= SURR_HI));
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    result_t r [2];
    int      n;
    logic    as_lead;
    n       = 0;
    as_lead = 1'b1;
    if (seq_left != 2'd0) begin
      if (b[7:6] == CONT_TAG) begin
        as_lead   = 1'b0;
        seq_point = {seq_point[CP_W-7:0], b[5:0]};
        seq_left  = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
          r[n] = scalar_ok(seq_point) ? make_result(seq_point, 1'b0)
                                      : make_result('0, 1'b1);
          n++;
          seq_point = '0;
        end
      end else begin
        // The open sequence is broken; the byte is then decoded on its own.
        r[n] = make_result('0, 1'b1);
        n++;
        seq_left  = '0;
        seq_point = '0;
      end
    end
    if (as_lead) begin
      if (b[7] == 1'b0) begin
        r[n] = make_result({13'd0, b}, 1'b0);
        n++;
      end else if (b[7:3] == LEAD4_TAG) begin
        seq_point = {18'd0, b[2:0]};
        seq_left  = 2'd3;
      end else if (b[7:4] == LEAD3_TAG) begin
        seq_point = {17'd0, b[3:0]};
        seq_left  = 2'd2;
      end else if (b[7:5] == LEAD2_TAG) begin
        seq_point = {16'd0, b[4:0]};
        seq_left  = 2'd1;
      end else begin
        r[n] = make_result('0, 1'b1);
        n++;
      end
    end
    if (n > 0)
      r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++)
      expected_points.push_back(r[i]);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      seq_left  = '0;
      seq_point = '0;
      expected_points.delete();
    end else begin
      if (in_valid && in_ready)
        predict_byte(in_byte_in);
      if (out_valid && out_ready) begin
        got.code_point = out_code_point;
        got.error      = out_error;
        got.last       = out_last;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result: cp=%h err=%b last=%b",
                   $time, got.code_point, got.error, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected cp=%h err=%b last=%b, actual cp=%h err=%b last=%b",
                     $time, want.code_point, want.error, want.last,
                     got.code_point, got.error, got.last);
            fail_count <= fail_count + 1;
          end
          if (want.error)
            error_count <= error_count + 1;
          checked_count <= checked_count + 1;
        end
      end
    end
    outstanding <= expected_points.size();
  end

endmodule

FILE: dv/utf8_stream_decoder_test.sv
`timescale 1ns / 100ps

module utf8_stream_decoder_test;
  import utf8sd_pkg::*;

  localparam int RANDOM_BYTES = 550;
  localparam int STALL_LIMIT  = 2000;

  typedef enum int {
    SEQ_ASCII,
    SEQ_TWO,
    SEQ_THREE,
    SEQ_FOUR,
    SEQ_CUT,
    SEQ_NOISE
  } seq_kind_t;

  logic            clk;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      in_byte_in = 8'h00;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [CP_W-1:0] out_code_point;
  logic            out_error;
  logic            out_last;

  int fail_count;
  int outstanding;
  int checked_count;
  int error_count;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  logic calm = 1'b0;

  utf8_stream_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_error      (out_error),
    .out_last       (out_last)
  );

  utf8_stream_decoder_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_error      (out_error),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .checked_count  (checked_count),
    .error_count    (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (calm)
      out_ready <= 1'b1;
    else
      out_ready <= ($urandom_range(0, 99) >= 9);
  end

  // Ends the run if no word moves on either channel for too long.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && ($urandom_range(0, 99) < 9)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      2: return {3'b110, 5'($urandom_range(0, 31))};
      3: return {4'b1110, 4'($urandom_range(0, 15))};
      default: begin
        // Mostly leads that can still give a valid point, a few past the range.
        if ($urandom_range(0, 3) != 0)
          return {5'b11110, 3'($urandom_range(0, 4))};
        else
          return {5'b11110, 3'($urandom_range(5, 7))};
      end
    endcase
  endfunction

  task automatic send_sequence(input int len, input int conts);
    send_byte(lead_byte(len));
    for (int i = 0; i < conts; i++)
      send_byte(cont_byte());
  endtask

  task automatic send_random_item();
    seq_kind_t kind;
    int        roll;
    int        len;
    roll = $urandom_range(0, 99);
    if (roll < 20)      kind = SEQ_ASCII;
    else if (roll < 40) kind = SEQ_TWO;
    else if (roll < 60) kind = SEQ_THREE;
    else if (roll < 78) kind = SEQ_FOUR;
    else if (roll < 90) kind = SEQ_CUT;
    else                kind = SEQ_NOISE;
    case (kind)
      SEQ_ASCII: send_byte(8'($urandom_range(0, 127)));
      SEQ_TWO:   send_sequence(2, 1);
      SEQ_THREE: send_sequence(3, 2);
      SEQ_FOUR:  send_sequence(4, 3);
      SEQ_CUT: begin
        // A lead with too few continuations; the next byte breaks it unless it is a continuation.
        len = $urandom_range(2, 4);
        send_sequence(len, $urandom_range(0, len - 2));
      end
      default: send_byte(8'($urandom));
    endcase
  endtask

  initial begin
    logic [7:0] directed [$];
    int         start_count;
    directed = '{8'h00, 8'h7F,
                 8'hC0, 8'h80,                  // overlong NUL
                 8'hF0, 8'h9F, 8'h98, 8'h80,    // four-byte point
                 8'hF4, 8'h90, 8'h80, 8'h80,    // above the Unicode range
                 8'hED, 8'hA0, 8'h80,           // surrogate
                 8'h80,                         // continuation with nothing open
                 8'hFF,                         // invalid lead
                 8'hC3, 8'h41,                  // two-byte cut by ASCII
                 8'hE2, 8'h82, 8'hC3, 8'hA9};   // three-byte cut by a new lead
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_byte(directed[i]);

    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      calm = (bytes_sent - start_count >= 250) && (bytes_sent - start_count < 350);
      send_random_item();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes of directed and random UTF-8, checked %0d results", bytes_sent,
             checked_count);
    $display("(%0d of them errors), with random stalls on both channels.", error_count);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/utf8sd_pkg.sv
rtl/core/utf8sd_dec.sv
rtl/core/utf8sd_rq.sv
rtl/core/utf8_stream_decoder.sv
dv/utf8_stream_decoder_checker.sv
dv/utf8_stream_decoder_test.sv
